### hw/rtl/scsc_pkg.sv
package scsc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned StatOutW = 32;

  localparam logic [CountW-1:0] CountMaxReset = 16'd3999;

  // operation codes of an input beat
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // status codes of a result beat
  localparam logic [StatusW-1:0] ST_IN_ORDER = 3'd0;
  localparam logic [StatusW-1:0] ST_GAP      = 3'd1;
  localparam logic [StatusW-1:0] ST_DUP      = 3'd2;
  localparam logic [StatusW-1:0] ST_LATE     = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd4;

endpackage

### hw/rtl/scsc_sat_cnt.sv
module scsc_sat_cnt #(
  parameter int unsigned Width = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         en_i,
  input  logic [scsc_pkg::CountW-1:0]  inc_i,
  output logic [Width-1:0]             cnt_o
);

  localparam int unsigned SumW =
    ((Width > scsc_pkg::CountW) ? Width : scsc_pkg::CountW) + 1;

  logic [Width-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]  sum;
  logic [SumW-1:0]  limit;

  assign limit = SumW'({Width{1'b1}});
  assign sum   = SumW'(cnt_q) + SumW'(inc_i);

  always_comb begin
    cnt_d = cnt_q;
    if (clr_i) begin
      cnt_d = '0;
    end else if (en_i) begin
      // clamp at all ones
      cnt_d = (sum >= limit) ? {Width{1'b1}} : Width'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

### hw/rtl/sample_count_sequence_checker_unit.sv
// Sequence checker for received sample counts. Each input beat either checks one sample
// count (classified as in order, gap, duplicate or late) or clears the sequence state and
// the statistics while keeping count_maximum. One beat is taken every clock cycle when the
// output side keeps up; an accepted beat is held in the input register and its result is
// loaded into the result register (one input register, one result register) once the
// result register is free. The rate is set by the sequence state loop: the compare
// against the expected count, the forward distance and the next-expected update all
// close combinationally. The five statistics ports show the saturating counters as
// they stand after the beat on the result port; counters are STAT_WIDTH bits wide and the
// ports carry their low 32 bits. count_maximum is written through cfg_we_i/cfg_wdata_i
// and must only be changed while no beat is in flight.
module sample_count_sequence_checker_unit #(
  parameter int unsigned STAT_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   cfg_we_i,
  input  logic [scsc_pkg::CountW-1:0]            cfg_wdata_i,

  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   operation_i,
  input  logic [scsc_pkg::CountW-1:0]            sample_count_i,
  input  logic                                   frame_error_i,

  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [scsc_pkg::StatusW-1:0]           status_o,
  output logic [scsc_pkg::CountW-1:0]            actual_count_o,
  output logic [scsc_pkg::CountW-1:0]            expected_value_o,
  output logic [scsc_pkg::CountW-1:0]            gap_start_o,
  output logic [scsc_pkg::CountW-1:0]            gap_end_o,
  output logic [scsc_pkg::CountW-1:0]            gap_length_o,
  output logic [scsc_pkg::StatOutW-1:0]          frames_seen_o,
  output logic [scsc_pkg::StatOutW-1:0]          errored_frames_o,
  output logic [scsc_pkg::StatOutW-1:0]          duplicates_seen_o,
  output logic [scsc_pkg::StatOutW-1:0]          missing_total_o,
  output logic [scsc_pkg::StatOutW-1:0]          late_arrivals_o
);

  localparam int unsigned CW = scsc_pkg::CountW;
  localparam int unsigned SW = scsc_pkg::StatusW;

  // configuration
  logic [CW-1:0] cnt_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_max_q <= scsc_pkg::CountMaxReset;
    end else if (cfg_we_i) begin
      cnt_max_q <= cfg_wdata_i;
    end
  end

  // input register
  logic          in_vld_q;
  logic          op_q;
  logic [CW-1:0] cnt_q;
  logic          err_q;
  logic          out_vld_q;
  logic          advance;

  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      cnt_q <= sample_count_i;
      err_q <= frame_error_i;
    end
  end

  // sequence state
  logic          started_q, started_d;
  logic [CW-1:0] last_q, last_d;
  logic [CW-1:0] next_q, next_d;

  logic          do_check, do_clear;
  logic          hit, dup_hit, in_window;
  logic [CW-1:0] fwd, half_max, follow_cnt, gap_end;

  assign do_check = advance & (op_q == scsc_pkg::OP_CHECK);
  assign do_clear = advance & (op_q == scsc_pkg::OP_CLEAR);

  assign hit        = (cnt_q == next_q);
  assign dup_hit    = (cnt_q == last_q);
  assign half_max   = cnt_max_q >> 1;
  // forward distance, wrapping through count_maximum when behind the expected count
  assign fwd        = (cnt_q >= next_q) ? (cnt_q - next_q)
                                        : (cnt_max_q - next_q + cnt_q + CW'(1));
  assign in_window  = (fwd <= half_max);
  assign follow_cnt = (cnt_q >= cnt_max_q) ? '0 : (cnt_q + CW'(1));
  assign gap_end    = (cnt_q == '0) ? cnt_max_q : (cnt_q - CW'(1));

  logic [SW-1:0] status_d;
  logic [CW-1:0] actual_d, expv_d, gs_d, ge_d, gl_d;
  logic          gap_ev, dup_ev, late_ev;

  always_comb begin
    started_d = started_q;
    last_d    = last_q;
    next_d    = next_q;
    status_d  = scsc_pkg::ST_IN_ORDER;
    actual_d  = cnt_q;
    expv_d    = next_q;
    gs_d      = '0;
    ge_d      = '0;
    gl_d      = '0;
    gap_ev    = 1'b0;
    dup_ev    = 1'b0;
    late_ev   = 1'b0;
    if (op_q == scsc_pkg::OP_CLEAR) begin
      started_d = 1'b0;
      last_d    = '0;
      next_d    = '0;
      status_d  = scsc_pkg::ST_CLEARED;
      actual_d  = '0;
      expv_d    = '0;
    end else if (!started_q) begin
      started_d = 1'b1;
      last_d    = cnt_q;
      next_d    = follow_cnt;
      expv_d    = cnt_q;
    end else if (hit) begin
      last_d = cnt_q;
      next_d = follow_cnt;
    end else if (dup_hit) begin
      status_d = scsc_pkg::ST_DUP;
      dup_ev   = 1'b1;
    end else if (in_window) begin
      status_d = scsc_pkg::ST_GAP;
      gs_d     = next_q;
      ge_d     = gap_end;
      gl_d     = fwd;
      gap_ev   = 1'b1;
      last_d   = cnt_q;
      next_d   = follow_cnt;
    end else begin
      status_d = scsc_pkg::ST_LATE;
      late_ev  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      next_q    <= '0;
    end else if (advance) begin
      started_q <= started_d;
      last_q    <= last_d;
      next_q    <= next_d;
    end
  end

  // result register
  logic [SW-1:0] status_q;
  logic [CW-1:0] actual_q, expv_q, gs_q, ge_q, gl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      actual_q <= actual_d;
      expv_q   <= expv_d;
      gs_q     <= gs_d;
      ge_q     <= ge_d;
      gl_q     <= gl_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = status_q;
  assign actual_count_o   = actual_q;
  assign expected_value_o = expv_q;
  assign gap_start_o      = gs_q;
  assign gap_end_o        = ge_q;
  assign gap_length_o     = gl_q;

  // statistics; they only move with a new result, so they stay aligned with the result port
  logic [STAT_WIDTH-1:0] total_cnt, err_cnt, dup_cnt, gap_cnt, late_cnt;
  logic [63:0]           total_x, err_x, dup_x, gap_x, late_x;

  scsc_sat_cnt #(.Width(STAT_WIDTH)) u_total (
    .clk_i, .rst_ni, .clr_i(do_clear), .en_i(do_check),
    .inc_i(CW'(1)), .cnt_o(total_cnt)
  );

  scsc_sat_cnt #(.Width(STAT_WIDTH)) u_err (
    .clk_i, .rst_ni, .clr_i(do_clear), .en_i(do_check & err_q),
    .inc_i(CW'(1)), .cnt_o(err_cnt)
  );

  scsc_sat_cnt #(.Width(STAT_WIDTH)) u_dup (
    .clk_i, .rst_ni, .clr_i(do_clear), .en_i(do_check & dup_ev),
    .inc_i(CW'(1)), .cnt_o(dup_cnt)
  );

  scsc_sat_cnt #(.Width(STAT_WIDTH)) u_gap (
    .clk_i, .rst_ni, .clr_i(do_clear), .en_i(do_check & gap_ev),
    .inc_i(fwd), .cnt_o(gap_cnt)
  );

  scsc_sat_cnt #(.Width(STAT_WIDTH)) u_late (
    .clk_i, .rst_ni, .clr_i(do_clear), .en_i(do_check & late_ev),
    .inc_i(CW'(1)), .cnt_o(late_cnt)
  );

  assign total_x = 64'(total_cnt);
  assign err_x   = 64'(err_cnt);
  assign dup_x   = 64'(dup_cnt);
  assign gap_x   = 64'(gap_cnt);
  assign late_x  = 64'(late_cnt);

  assign frames_seen_o     = total_x[scsc_pkg::StatOutW-1:0];
  assign errored_frames_o  = err_x[scsc_pkg::StatOutW-1:0];
  assign duplicates_seen_o = dup_x[scsc_pkg::StatOutW-1:0];
  assign missing_total_o   = gap_x[scsc_pkg::StatOutW-1:0];
  assign late_arrivals_o   = late_x[scsc_pkg::StatOutW-1:0];

  // checks
  a_clear_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == scsc_pkg::ST_CLEARED) |->
      (frames_seen_o == '0) && (actual_count_o == '0) && (missing_total_o == '0))
    else $error("cleared result with non-zero fields");

  a_gap_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != scsc_pkg::ST_GAP) |->
      (gap_start_o == '0) && (gap_end_o == '0) && (gap_length_o == '0))
    else $error("gap fields set without a gap");

  a_stats_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(frames_seen_o) && $stable(missing_total_o))
    else $error("statistics moved under a stalled result");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule
